// ----- hdl/lett_pkg.sv -----
`timescale 1ns / 1ps

package lett_pkg;

  localparam int ENTRIES    = 16;
  localparam int INPUT_BITS = 16;
  localparam int STATE_BITS = 8;
  localparam int TAG_BITS   = 8;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  // operation codes
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_LEARN  = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_EXISTS  = 2'd1;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_CREATED = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // search token passed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic [INPUT_BITS-1:0] change;
    logic [INPUT_BITS-1:0] levels;
    logic [STATE_BITS-1:0] from_st;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [STATE_BITS-1:0] hit_to;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
    logic [CNT_W-1:0]      count;
  } tok_t;

  // update broadcast from the control logic to every cell
  typedef struct packed {
    logic                  learn_wr;
    logic                  remove_wr;
    logic                  clear_all;
    logic [IDX_W-1:0]      idx;
    logic [TAG_BITS-1:0]   tag;
    logic [INPUT_BITS-1:0] change;
    logic [INPUT_BITS-1:0] levels;
    logic [STATE_BITS-1:0] from_st;
    logic [STATE_BITS-1:0] to_st;
  } wr_t;

endpackage

// ----- hdl/lett_cell.sv -----
`timescale 1ns / 1ps

module lett_cell import lett_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [TAG_BITS-1:0] page_id,
  input  logic [IDX_W-1:0]    cell_index,
  input  tok_t                tok_in,
  input  wr_t                 wr,
  output tok_t                tok_out
);

  logic [TAG_BITS-1:0]   tag;
  logic [INPUT_BITS-1:0] levels;
  logic [INPUT_BITS-1:0] change_mask;
  logic [STATE_BITS-1:0] from_st;
  logic [STATE_BITS-1:0] to_st;
  logic                  match;
  tok_t                  tok_next;

  // compare this entry against the passing token
  assign match = (page_id != '0) && (tag == page_id) && (levels == tok_in.levels) &&
                 (change_mask == tok_in.change) && (from_st == tok_in.from_st);

  always_comb begin
    tok_next = tok_in;
    if (tag != '0) begin
      tok_next.count = tok_in.count + CNT_W'(1);
    end
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = cell_index;
      tok_next.hit_to  = to_st;
    end
    if ((tag == '0) && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = cell_index;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // entry tag, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (wr.clear_all) begin
      tag <= '0;
    end else if (wr.remove_wr && (wr.idx == cell_index)) begin
      tag <= '0;
    end else if (wr.learn_wr && (wr.idx == cell_index)) begin
      tag <= wr.tag;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr.learn_wr && (wr.idx == cell_index)) begin
      levels      <= wr.levels;
      change_mask <= wr.change;
      from_st     <= wr.from_st;
      to_st       <= wr.to_st;
    end
  end

endmodule

// ----- hdl/learnable_edge_transition_table_core.sv -----
`timescale 1ns / 1ps
// Learnable transition table driven by changes on a contact word.
// Item channel: kind, input_word, match_state and next_state are taken at
// a clock edge with start high and busy low. kind selects read, learn,
// remove or clear all.
// Result channel: done pulses for one cycle with status, present_state and
// occupied_count; there is no back pressure, the result must be taken then.
// Configuration: cfg_data is written to the page register when cfg_valid
// and cfg_ready are high; cfg_ready is high whenever the block is idle.
// Sequence: done rises once the search token has passed the launch register,
// the row of 16 entry cells, one cell per cycle, and the result registers;
// busy is low in the done cycle, so a new item can be started there; no new
// item is taken while busy is high, so items do not overlap.
// Reset: all entries empty, last input and present state zero, page 1.

module learnable_edge_transition_table_core import lett_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [INPUT_BITS-1:0] input_word,
  input  logic [STATE_BITS-1:0] match_state,
  input  logic [STATE_BITS-1:0] next_state,
  output logic                  done,
  output logic [1:0]            status,
  output logic [STATE_BITS-1:0] present_state,
  output logic [CNT_W-1:0]      occupied_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TAG_BITS-1:0]   cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state;
  logic [TAG_BITS-1:0]   page_id;
  logic [INPUT_BITS-1:0] last_input;
  logic [1:0]            op_kind;
  logic [INPUT_BITS-1:0] op_word;
  logic [STATE_BITS-1:0] op_next;
  tok_t                  head_tok;
  tok_t                  head_next;
  tok_t                  chain [ENTRIES];
  tok_t                  tail;
  wr_t                   wr;
  logic                  accept;
  logic [INPUT_BITS-1:0] in_change;
  logic                  has_change;
  logic [1:0]            status_next;
  logic [STATE_BITS-1:0] state_next;
  logic [CNT_W-1:0]      count_next;

  assign accept     = start && !busy;
  assign busy       = (state == ST_SCAN);
  assign cfg_ready  = !busy;
  assign in_change  = last_input ^ input_word;
  assign tail       = chain[ENTRIES-1];
  assign has_change = (tail.change != '0);

  // page register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_id <= TAG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      page_id <= cfg_data;
    end
  end

  // search token built from the incoming item
  always_comb begin
    head_next         = '0;
    head_next.valid   = accept;
    head_next.change  = in_change;
    head_next.levels  = in_change & input_word;
    head_next.from_st = match_state;
  end

  // launch the search token into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      head_tok <= '0;
    end else begin
      head_tok <= head_next;
    end
  end

  // item fields kept for write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= kind;
      op_word <= input_word;
      op_next <= next_state;
    end
  end

  // row of entry cells
  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lett_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .page_id    (page_id),
        .cell_index (IDX_W'(gi)),
        .tok_in     ((gi == 0) ? head_tok : chain[(gi == 0) ? 0 : gi - 1]),
        .wr         (wr),
        .tok_out    (chain[gi])
      );
    end
  endgenerate

  // decide the outcome when the token leaves the last cell
  always_comb begin
    wr          = '0;
    wr.tag      = page_id;
    wr.change   = tail.change;
    wr.levels   = tail.levels;
    wr.from_st  = tail.from_st;
    wr.to_st    = op_next;
    status_next = STAT_NONE;
    state_next  = present_state;
    count_next  = tail.count;
    case (op_kind)
      KIND_READ: begin
        if (has_change && tail.hit) begin
          state_next = tail.hit_to;
        end
      end
      KIND_LEARN: begin
        if (has_change) begin
          if (tail.hit) begin
            status_next = STAT_EXISTS;
          end else if ((page_id != '0) && tail.free) begin
            status_next = STAT_CREATED;
            wr.learn_wr = tail.valid;
            wr.idx      = tail.free_idx;
            count_next  = tail.count + CNT_W'(1);
          end else begin
            status_next = STAT_FULL;
          end
        end
      end
      KIND_REMOVE: begin
        if (has_change && tail.hit) begin
          status_next  = STAT_DONE;
          wr.remove_wr = tail.valid;
          wr.idx       = tail.hit_idx;
          count_next   = tail.count - CNT_W'(1);
        end
      end
      default: begin
        wr.clear_all = tail.valid;
        status_next  = (tail.count != '0) ? STAT_DONE : STAT_NONE;
        count_next   = '0;
      end
    endcase
  end

  // sequencing, remembered input and result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      last_input     <= '0;
      present_state  <= '0;
      status         <= STAT_NONE;
      occupied_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            state          <= ST_IDLE;
            done           <= 1'b1;
            status         <= status_next;
            present_state  <= state_next;
            occupied_count <= count_next;
            if ((op_kind == KIND_LEARN) ||
                ((op_kind != KIND_CLEAR) && has_change)) begin
              last_input <= op_word;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
